/* hdl/pppcnf_pkg.sv */
// Types, codes and reset constants shared by the PPP control negotiation core.
// No dependencies; every other file in hdl/ refers to this package by scope.
`default_nettype none

package pppcnf_pkg;

   typedef enum logic [2:0] {
      PH_STOPPED  = 3'd0,
      PH_STOPPING = 3'd1,
      PH_REQSENT  = 3'd2,
      PH_ACKRCVD  = 3'd3,
      PH_ACKSENT  = 3'd4,
      PH_OPENED   = 3'd5
   } phase_type;

   localparam logic [7:0] CODE_REQ  = 8'd1;
   localparam logic [7:0] CODE_ACK  = 8'd2;
   localparam logic [7:0] CODE_NAK  = 8'd3;
   localparam logic [7:0] CODE_REJ  = 8'd4;
   localparam logic [7:0] CODE_TREQ = 8'd5;
   localparam logic [7:0] CODE_TACK = 8'd6;
   localparam logic [7:0] CODE_CREJ = 8'd7;

   localparam logic KIND_PACKET    = 1'b0;
   localparam logic KIND_PROTO_REJ = 1'b1;

   localparam logic CMD_TICK  = 1'b0;

   localparam logic [1:0] VERDICT_ACK = 2'd0;
   localparam logic [1:0] VERDICT_NAK = 2'd1;

   localparam logic [1:0] CSR_MAX_REQUESTS  = 2'd0;
   localparam logic [1:0] CSR_RESTART_TICKS = 2'd1;
   localparam logic [1:0] CSR_OWN_PROTOCOL  = 2'd2;

   localparam logic [7:0]  RST_MAX_REQUESTS  = 8'd10;
   localparam logic [15:0] RST_RESTART_TICKS = 16'd3;
   localparam logic [15:0] RST_OWN_PROTOCOL  = 16'hC021;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  budget_left;
      logic [7:0]  ident_counter;
      logic [7:0]  pending_ident;
      logic        answer_seen;
      logic [15:0] timer_left;
      logic        timer_armed;
   } ctl_state_type;

   typedef struct packed {
      logic [7:0]  max_requests;
      logic [15:0] restart_ticks;
      logic [15:0] own_protocol;
   } cfg_type;

   typedef struct packed {
      logic        command;
      logic [15:0] frame_protocol;
      logic [7:0]  frame_code;
      logic [7:0]  frame_ident;
      logic [11:0] frame_bytes;
      logic [15:0] declared_length;
      logic [1:0]  option_verdict;
   } item_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_code;
      logic [7:0] out_ident;
   } result_type;

   typedef struct packed {
      logic [1:0]            count;
      result_type [1:0]      res;
   } step_out_type;

endpackage

`default_nettype wire

/* hdl/pppcnf_step.sv */
// Combinational step of the negotiation automaton: next state and up to two results.
// Depends on pppcnf_pkg.
`default_nettype none

module pppcnf_step (
   input  pppcnf_pkg::ctl_state_type state_cur,
   input  pppcnf_pkg::cfg_type       cfg,
   input  pppcnf_pkg::item_type      item,
   output pppcnf_pkg::ctl_state_type state_next,
   output pppcnf_pkg::step_out_type  step_out
);

   function automatic pppcnf_pkg::ctl_state_type use_budget(pppcnf_pkg::ctl_state_type s);
      pppcnf_pkg::ctl_state_type t;
      t = s;
      if (t.budget_left != 8'd0) begin
         t.budget_left = t.budget_left - 8'd1;
      end
      return t;
   endfunction

   function automatic pppcnf_pkg::ctl_state_type arm(pppcnf_pkg::ctl_state_type s,
                                                    logic [15:0] ticks);
      pppcnf_pkg::ctl_state_type t;
      t = s;
      t.timer_left  = ticks;
      t.timer_armed = 1'b1;
      return t;
   endfunction

   function automatic pppcnf_pkg::ctl_state_type disarm(pppcnf_pkg::ctl_state_type s);
      pppcnf_pkg::ctl_state_type t;
      t = s;
      t.timer_left  = 16'd0;
      t.timer_armed = 1'b0;
      return t;
   endfunction

   // Fresh request takes a new identifier and a full budget; a retransmit keeps both.
   function automatic pppcnf_pkg::ctl_state_type send_req(pppcnf_pkg::ctl_state_type s,
                                                         logic again,
                                                         pppcnf_pkg::cfg_type c);
      pppcnf_pkg::ctl_state_type t;
      t = s;
      if (!again) begin
         t.budget_left   = c.max_requests;
         t.ident_counter = t.ident_counter + 8'd1;
         t.pending_ident = t.ident_counter;
      end
      t.answer_seen = 1'b0;
      t = use_budget(t);
      t = arm(t, c.restart_ticks);
      return t;
   endfunction

   function automatic pppcnf_pkg::step_out_type emit(pppcnf_pkg::step_out_type o,
                                                    logic kind, logic [7:0] code,
                                                    logic [7:0] ident);
      pppcnf_pkg::step_out_type t;
      t = o;
      t.res[t.count[0]] = '{out_kind: kind, out_code: code, out_ident: ident};
      t.count = t.count + 2'd1;
      return t;
   endfunction

   logic [16:0] need_bytes;
   logic        len_bad;
   logic        ident_match;

   assign need_bytes  = {1'b0, item.declared_length} + 17'd4;
   assign len_bad     = (item.frame_bytes <= 12'd6) || (need_bytes > {5'd0, item.frame_bytes});
   assign ident_match = (item.frame_ident == state_cur.pending_ident) && !state_cur.answer_seen;

   always_comb begin
      pppcnf_pkg::ctl_state_type s;
      pppcnf_pkg::step_out_type  o;
      logic [7:0]                reply;
      s = state_cur;
      o = '0;
      reply = pppcnf_pkg::CODE_REJ;
      if (item.command == pppcnf_pkg::CMD_TICK) begin
         if (s.timer_armed) begin
            if (s.timer_left > 16'd1) begin
               s.timer_left = s.timer_left - 16'd1;
            end else begin
               s = disarm(s);
               case (s.phase)
                  pppcnf_pkg::PH_STOPPING: begin
                     if (s.budget_left == 8'd0) begin
                        s.phase = pppcnf_pkg::PH_STOPPED;
                     end else begin
                        s.ident_counter = s.ident_counter + 8'd1;
                        s.pending_ident = s.ident_counter;
                        o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TREQ,
                                 s.pending_ident);
                        s = arm(s, cfg.restart_ticks);
                        s = use_budget(s);
                     end
                  end
                  pppcnf_pkg::PH_REQSENT, pppcnf_pkg::PH_ACKRCVD,
                  pppcnf_pkg::PH_ACKSENT: begin
                     if (s.budget_left == 8'd0) begin
                        s.phase = pppcnf_pkg::PH_STOPPED;
                     end else begin
                        s = send_req(s, 1'b1, cfg);
                        o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_REQ,
                                 s.pending_ident);
                        if (s.phase == pppcnf_pkg::PH_ACKRCVD) begin
                           s.phase = pppcnf_pkg::PH_REQSENT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
      end else if (item.frame_bytes >= 12'd4) begin
         if (item.frame_protocol != cfg.own_protocol) begin
            o = emit(o, pppcnf_pkg::KIND_PROTO_REJ, 8'd0, 8'd0);
         end else if (!len_bad) begin
            case (item.frame_code)
               pppcnf_pkg::CODE_REQ: begin
                  if (s.phase inside {pppcnf_pkg::PH_OPENED, pppcnf_pkg::PH_STOPPED}) begin
                     s = send_req(s, 1'b0, cfg);
                     o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_REQ,
                              s.pending_ident);
                     s.phase = pppcnf_pkg::PH_REQSENT;
                  end
                  if (item.option_verdict == pppcnf_pkg::VERDICT_ACK) begin
                     reply = pppcnf_pkg::CODE_ACK;
                  end else if (item.option_verdict == pppcnf_pkg::VERDICT_NAK) begin
                     reply = pppcnf_pkg::CODE_NAK;
                  end
                  o = emit(o, pppcnf_pkg::KIND_PACKET, reply, item.frame_ident);
                  if (reply == pppcnf_pkg::CODE_ACK) begin
                     if (s.phase == pppcnf_pkg::PH_ACKRCVD) begin
                        s = disarm(s);
                        s.phase = pppcnf_pkg::PH_OPENED;
                     end else begin
                        s.phase = pppcnf_pkg::PH_ACKSENT;
                     end
                  end else if (s.phase != pppcnf_pkg::PH_ACKRCVD) begin
                     s.phase = pppcnf_pkg::PH_REQSENT;
                  end
               end
               pppcnf_pkg::CODE_ACK: begin
                  if (ident_match) begin
                     s.answer_seen = 1'b1;
                     case (s.phase)
                        pppcnf_pkg::PH_STOPPED: begin
                           o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TACK,
                                    item.frame_ident);
                        end
                        pppcnf_pkg::PH_REQSENT: begin
                           s.phase       = pppcnf_pkg::PH_ACKRCVD;
                           s.budget_left = cfg.max_requests;
                        end
                        pppcnf_pkg::PH_ACKSENT: begin
                           s = disarm(s);
                           s.phase       = pppcnf_pkg::PH_OPENED;
                           s.budget_left = cfg.max_requests;
                        end
                        pppcnf_pkg::PH_ACKRCVD, pppcnf_pkg::PH_OPENED: begin
                           s = disarm(s);
                           s = send_req(s, 1'b0, cfg);
                           o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_REQ,
                                    s.pending_ident);
                           s.phase = pppcnf_pkg::PH_REQSENT;
                        end
                        default: ;
                     endcase
                  end
               end
               pppcnf_pkg::CODE_NAK, pppcnf_pkg::CODE_REJ: begin
                  if (ident_match) begin
                     s.answer_seen = 1'b1;
                     case (s.phase)
                        pppcnf_pkg::PH_STOPPED: begin
                           o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TACK,
                                    item.frame_ident);
                        end
                        pppcnf_pkg::PH_REQSENT, pppcnf_pkg::PH_ACKSENT: begin
                           s = disarm(s);
                           s = send_req(s, 1'b0, cfg);
                           o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_REQ,
                                    s.pending_ident);
                        end
                        pppcnf_pkg::PH_ACKRCVD, pppcnf_pkg::PH_OPENED: begin
                           s = disarm(s);
                           s = send_req(s, 1'b0, cfg);
                           o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_REQ,
                                    s.pending_ident);
                           s.phase = pppcnf_pkg::PH_REQSENT;
                        end
                        default: ;
                     endcase
                  end
               end
               pppcnf_pkg::CODE_TREQ: begin
                  if (s.phase inside {pppcnf_pkg::PH_ACKRCVD, pppcnf_pkg::PH_ACKSENT}) begin
                     s.phase = pppcnf_pkg::PH_REQSENT;
                  end else if (s.phase == pppcnf_pkg::PH_OPENED) begin
                     s.budget_left = 8'd0;
                     s.phase       = pppcnf_pkg::PH_STOPPING;
                     s = arm(s, cfg.restart_ticks);
                  end
                  o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TACK,
                           item.frame_ident);
               end
               pppcnf_pkg::CODE_TACK: begin
                  if (s.phase == pppcnf_pkg::PH_STOPPING) begin
                     s = disarm(s);
                     s.phase = pppcnf_pkg::PH_STOPPED;
                  end else if (s.phase == pppcnf_pkg::PH_ACKRCVD) begin
                     s.phase = pppcnf_pkg::PH_REQSENT;
                  end else if (s.phase == pppcnf_pkg::PH_OPENED) begin
                     s = send_req(s, 1'b0, cfg);
                     o = emit(o, pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_REQ,
                              s.pending_ident);
                     s.phase = pppcnf_pkg::PH_REQSENT;
                  end
               end
               pppcnf_pkg::CODE_CREJ: begin
                  if (s.phase == pppcnf_pkg::PH_ACKRCVD) begin
                     s.phase = pppcnf_pkg::PH_REQSENT;
                  end
               end
               default: ;
            endcase
         end
      end
      state_next = s;
      step_out   = o;
   end

endmodule

`default_nettype wire

/* hdl/pppcnf_outq.sv */
// Two-entry result queue: loads all results of one step at once, drains one beat a cycle while rsp_tready is high.
// Depends on pppcnf_pkg.
`default_nettype none

module pppcnf_outq (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  pppcnf_pkg::step_out_type  step_out,
   input  pppcnf_pkg::phase_type     link_phase,
   output logic                      free,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output logic [23:0]               rsp_tdata,   // out_code[7:0], out_ident[15:8], link_state[18:16]
   output logic                      rsp_tuser,   // out_kind
   output logic                      rsp_tlast
);

   typedef struct packed {
      pppcnf_pkg::result_type r;
      pppcnf_pkg::phase_type  link;
      logic                   last;
   } slot_type;

   slot_type   slot0_ff, slot0_in;
   slot_type   slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic       load;

   assign pop  = (count_ff != 2'd0) && rsp_tready;
   assign free = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);
   assign load = push && (step_out.count != 2'd0);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (load) begin
         slot0_in = '{r: step_out.res[0], link: link_phase,
                      last: (step_out.count == 2'd1)};
         slot1_in = '{r: step_out.res[1], link: link_phase, last: 1'b1};
         count_in = step_out.count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {5'd0, slot0_ff.link, slot0_ff.r.out_ident, slot0_ff.r.out_code};
   assign rsp_tuser  = slot0_ff.r.out_kind;
   assign rsp_tlast  = slot0_ff.last;

endmodule

`default_nettype wire

/* hdl/ppp_control_negotiation_fsm_core.sv */
// PPP control-protocol negotiation core: input register, step logic, result queue.
// Depends on pppcnf_pkg, pppcnf_step and pppcnf_outq.
//
// Use:
//   req_*  : one beat per timer tick (tuser = 0) or received frame header (tuser = 1).
//   rsp_*  : zero, one or two beats per input beat, in order; tlast marks the final
//            beat of each input, tuser marks a protocol-reject.
//   csr_*  : register writes, index 0 max_requests, 1 restart_ticks, 2 own_protocol;
//            always ready, other indexes ignored. Write only while idle.
// Path: an accepted beat is registered in the input register, stepped once the result
//   queue is free, and its results are registered in the queue before they leave on rsp_*.
// Throughput: one input beat a cycle while each yields at most one result and rsp_tready
//   stays high; an input giving two results holds the step, as the two-entry result
//   queue must drain to one entry before the next step loads.
// Reset: link state stopped, timer disarmed, counters zero, registers at defaults.
// Stall: when rsp_tready is low the queue holds, the step waits, and once the
//   input register is full req_tready drops.
`default_nettype none

module ppp_control_negotiation_fsm_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // frame_protocol[15:0], frame_code[23:16], frame_ident[31:24], frame_bytes[43:32],
   // declared_length[59:44], option_verdict[61:60]
   input  wire  [63:0] req_tdata,
   input  wire         req_tuser,    // command
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,    // out_code[7:0], out_ident[15:8], link_state[18:16]
   output logic        rsp_tuser,    // out_kind
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_data
);

   logic                      in_valid_ff, in_valid_in;
   pppcnf_pkg::item_type      item_ff;
   pppcnf_pkg::ctl_state_type state_ff, state_in;
   pppcnf_pkg::cfg_type       cfg_ff, cfg_in;
   pppcnf_pkg::step_out_type  step_out;
   logic                      q_free;
   logic                      advance;
   logic                      req_beat;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && q_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in = req_beat || (in_valid_ff && !advance);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pppcnf_pkg::CSR_MAX_REQUESTS:  cfg_in.max_requests  = csr_data[7:0];
            pppcnf_pkg::CSR_RESTART_TICKS: cfg_in.restart_ticks = csr_data;
            pppcnf_pkg::CSR_OWN_PROTOCOL:  cfg_in.own_protocol  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{phase: pppcnf_pkg::PH_STOPPED, default: '0};
         cfg_ff      <= '{max_requests:  pppcnf_pkg::RST_MAX_REQUESTS,
                          restart_ticks: pppcnf_pkg::RST_RESTART_TICKS,
                          own_protocol:  pppcnf_pkg::RST_OWN_PROTOCOL};
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff <= '{command:         req_tuser,
                      frame_protocol:  req_tdata[15:0],
                      frame_code:      req_tdata[23:16],
                      frame_ident:     req_tdata[31:24],
                      frame_bytes:     req_tdata[43:32],
                      declared_length: req_tdata[59:44],
                      option_verdict:  req_tdata[61:60]};
      end
   end

   pppcnf_step u_step (
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .item       (item_ff),
      .state_next (state_in),
      .step_out   (step_out)
   );

   pppcnf_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (advance),
      .step_out   (step_out),
      .link_phase (state_in.phase),
      .free       (q_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a protocol-reject beat carries no code and no identifier
   a_prej_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == 16'd0)
      else $error("protocol-reject beat with non-zero code or identifier");

   a_disarmed_clear: assert property (@(posedge clock) disable iff (reset)
      !state_ff.timer_armed |-> state_ff.timer_left == 16'd0)
      else $error("disarmed timer holds a count");

   a_opened_no_timer: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == pppcnf_pkg::PH_OPENED |-> !state_ff.timer_armed)
      else $error("restart timer running in opened state");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second result of a step missing");

endmodule

`default_nettype wire

/* dv/tb_ppp_control_negotiation_fsm_core.sv */
// Self-checking bench for the PPP control negotiation core: a directed table then random
// ticks and frame headers under six register settings, checked against a link predictor.
// Depends on hdl/pppcnf_pkg.sv and hdl/ppp_control_negotiation_fsm_core.sv.
`timescale 1ns / 1ps

module tb_ppp_control_negotiation_fsm_core;

   localparam logic       CMD_FRAME    = 1'b1;
   localparam logic [1:0] VERDICT_REJ  = 2'd2;
   localparam logic [1:0] VERDICT_ODD  = 2'd3;
   localparam logic [7:0] CODE_NONE    = 8'd0;
   localparam logic [7:0] CODE_TOP     = 8'd255;
   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 175;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic                  kind;
      logic [7:0]            code;
      logic [7:0]            ident;
      pppcnf_pkg::phase_type state;
      logic                  is_last;
   } reply_type;

   typedef struct {
      pppcnf_pkg::item_type it;
      logic                 typed;
      int                   n;
      reply_type            r0;
      reply_type            r1;
   } plan_row_type;

   localparam reply_type NO_REPLY = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // link predictor state and its copy of the registers
   pppcnf_pkg::phase_type lnk_phase = pppcnf_pkg::PH_STOPPED;
   logic [7:0]  budget = '0;
   logic [7:0]  ident_ctr = '0;
   logic [7:0]  pend_id = '0;
   logic        answered = 1'b0;
   logic [15:0] tmr_left = '0;
   logic        tmr_armed = 1'b0;
   logic [7:0]  cfg_max_req = pppcnf_pkg::RST_MAX_REQUESTS;
   logic [15:0] cfg_restart = pppcnf_pkg::RST_RESTART_TICKS;
   logic [15:0] cfg_proto = pppcnf_pkg::RST_OWN_PROTOCOL;

   pppcnf_pkg::result_type step_buf[$];
   reply_type              reply_q[$];

   int unsigned fail_count = 0;
   int unsigned items_sent = 0;
   int unsigned replies_seen = 0;
   int unsigned cycle_count = 0;
   int          send_idle_pct = 10;
   int          recv_idle_pct = 85;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   ppp_control_negotiation_fsm_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic void emit(logic kind, logic [7:0] code, logic [7:0] id);
      if (step_buf.size() < 2) step_buf.push_back('{kind, code, id});
   endfunction

   function automatic void arm_timer();
      tmr_left = cfg_restart;
      tmr_armed = 1'b1;
   endfunction

   function automatic void disarm_timer();
      tmr_left = '0;
      tmr_armed = 1'b0;
   endfunction

   function automatic void spend_budget();
      if (budget != 0) budget--;
   endfunction

   // a fresh request takes a new identifier and refills the budget; a resend keeps both
   function automatic void send_conf_req(logic again);
      if (!again) begin
         budget = cfg_max_req;
         ident_ctr++;
         pend_id = ident_ctr;
      end
      answered = 1'b0;
      emit(pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_REQ, pend_id);
      spend_budget();
      arm_timer();
   endfunction

   // advance the link by one beat; leaves the packets it sends in step_buf
   function automatic void negotiate_step(pppcnf_pkg::item_type it);
      logic [7:0] reply;
      step_buf.delete();
      if (it.command == pppcnf_pkg::CMD_TICK) begin
         if (tmr_armed) begin
            if (tmr_left > 1) begin
               tmr_left--;
            end else begin
               disarm_timer();
               case (lnk_phase)
                  pppcnf_pkg::PH_STOPPING: begin
                     if (budget == 0) begin
                        lnk_phase = pppcnf_pkg::PH_STOPPED;
                     end else begin
                        ident_ctr++;
                        pend_id = ident_ctr;
                        emit(pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TREQ, pend_id);
                        arm_timer();
                        spend_budget();
                     end
                  end
                  pppcnf_pkg::PH_REQSENT, pppcnf_pkg::PH_ACKRCVD,
                  pppcnf_pkg::PH_ACKSENT: begin
                     if (budget == 0) begin
                        lnk_phase = pppcnf_pkg::PH_STOPPED;
                     end else begin
                        send_conf_req(1'b1);
                        if (lnk_phase == pppcnf_pkg::PH_ACKRCVD)
                           lnk_phase = pppcnf_pkg::PH_REQSENT;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end else if (it.frame_bytes < 4) begin
         // runt: drop silently
      end else if (it.frame_protocol != cfg_proto) begin
         emit(pppcnf_pkg::KIND_PROTO_REJ, 8'd0, 8'd0);
      end else if (it.frame_bytes <= 6 || 32'd4 + it.declared_length > it.frame_bytes) begin
         // bad length: drop
      end else begin
         case (it.frame_code)
            pppcnf_pkg::CODE_REQ: begin
               if (lnk_phase == pppcnf_pkg::PH_OPENED ||
                   lnk_phase == pppcnf_pkg::PH_STOPPED) begin
                  send_conf_req(1'b0);
                  lnk_phase = pppcnf_pkg::PH_REQSENT;
               end
               reply = pppcnf_pkg::CODE_REJ;
               if (it.option_verdict == pppcnf_pkg::VERDICT_ACK)
                  reply = pppcnf_pkg::CODE_ACK;
               else if (it.option_verdict == pppcnf_pkg::VERDICT_NAK)
                  reply = pppcnf_pkg::CODE_NAK;
               emit(pppcnf_pkg::KIND_PACKET, reply, it.frame_ident);
               if (reply == pppcnf_pkg::CODE_ACK) begin
                  if (lnk_phase == pppcnf_pkg::PH_ACKRCVD) begin
                     disarm_timer();
                     lnk_phase = pppcnf_pkg::PH_OPENED;
                  end else begin
                     lnk_phase = pppcnf_pkg::PH_ACKSENT;
                  end
               end else if (lnk_phase != pppcnf_pkg::PH_ACKRCVD) begin
                  lnk_phase = pppcnf_pkg::PH_REQSENT;
               end
            end
            pppcnf_pkg::CODE_ACK: begin
               if (it.frame_ident == pend_id && !answered) begin
                  answered = 1'b1;
                  case (lnk_phase)
                     pppcnf_pkg::PH_STOPPED:
                        emit(pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TACK, it.frame_ident);
                     pppcnf_pkg::PH_REQSENT: begin
                        lnk_phase = pppcnf_pkg::PH_ACKRCVD;
                        budget = cfg_max_req;
                     end
                     pppcnf_pkg::PH_ACKSENT: begin
                        disarm_timer();
                        lnk_phase = pppcnf_pkg::PH_OPENED;
                        budget = cfg_max_req;
                     end
                     pppcnf_pkg::PH_ACKRCVD, pppcnf_pkg::PH_OPENED: begin
                        disarm_timer();
                        send_conf_req(1'b0);
                        lnk_phase = pppcnf_pkg::PH_REQSENT;
                     end
                     default: ;
                  endcase
               end
            end
            pppcnf_pkg::CODE_NAK, pppcnf_pkg::CODE_REJ: begin
               if (it.frame_ident == pend_id && !answered) begin
                  answered = 1'b1;
                  case (lnk_phase)
                     pppcnf_pkg::PH_STOPPED:
                        emit(pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TACK, it.frame_ident);
                     pppcnf_pkg::PH_REQSENT, pppcnf_pkg::PH_ACKSENT: begin
                        disarm_timer();
                        send_conf_req(1'b0);
                     end
                     pppcnf_pkg::PH_ACKRCVD, pppcnf_pkg::PH_OPENED: begin
                        disarm_timer();
                        send_conf_req(1'b0);
                        lnk_phase = pppcnf_pkg::PH_REQSENT;
                     end
                     default: ;
                  endcase
               end
            end
            pppcnf_pkg::CODE_TREQ: begin
               if (lnk_phase == pppcnf_pkg::PH_ACKRCVD ||
                   lnk_phase == pppcnf_pkg::PH_ACKSENT) begin
                  lnk_phase = pppcnf_pkg::PH_REQSENT;
               end else if (lnk_phase == pppcnf_pkg::PH_OPENED) begin
                  budget = '0;
                  lnk_phase = pppcnf_pkg::PH_STOPPING;
                  arm_timer();
               end
               emit(pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TACK, it.frame_ident);
            end
            pppcnf_pkg::CODE_TACK: begin
               if (lnk_phase == pppcnf_pkg::PH_STOPPING) begin
                  disarm_timer();
                  lnk_phase = pppcnf_pkg::PH_STOPPED;
               end else if (lnk_phase == pppcnf_pkg::PH_ACKRCVD) begin
                  lnk_phase = pppcnf_pkg::PH_REQSENT;
               end else if (lnk_phase == pppcnf_pkg::PH_OPENED) begin
                  send_conf_req(1'b0);
                  lnk_phase = pppcnf_pkg::PH_REQSENT;
               end
            end
            pppcnf_pkg::CODE_CREJ: begin
               if (lnk_phase == pppcnf_pkg::PH_ACKRCVD) lnk_phase = pppcnf_pkg::PH_REQSENT;
            end
            default: ;
         endcase
      end
   endfunction

   function automatic pppcnf_pkg::item_type frame_hdr(logic [7:0] code, logic [7:0] id,
                                                      logic [11:0] nbytes, logic [15:0] dlen,
                                                      logic [1:0] verdict,
                                                      logic [15:0] proto);
      frame_hdr = '{CMD_FRAME, proto, code, id, nbytes, dlen, verdict};
   endfunction

   // mostly well-formed frames for the served protocol, answers usually carrying the
   // identifier in flight; the rest is ticks and noise
   function automatic pppcnf_pkg::item_type random_item();
      pppcnf_pkg::item_type it;
      int                   pick;
      int                   nb;
      it.command         = CMD_FRAME;
      it.frame_protocol  = 16'($urandom_range(0, 65535));
      it.frame_code      = 8'($urandom_range(0, 255));
      it.frame_ident     = 8'($urandom_range(0, 255));
      it.frame_bytes     = 12'($urandom_range(0, 4095));
      it.declared_length = 16'($urandom_range(0, 65535));
      it.option_verdict  = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 30) begin
         it.command = pppcnf_pkg::CMD_TICK;
         return it;
      end
      if ($urandom_range(0, 9) != 0) it.frame_protocol = cfg_proto;
      pick = $urandom_range(0, 99);
      if (pick < 30)      it.frame_code = pppcnf_pkg::CODE_REQ;
      else if (pick < 50) it.frame_code = pppcnf_pkg::CODE_ACK;
      else if (pick < 60) it.frame_code = pppcnf_pkg::CODE_NAK;
      else if (pick < 68) it.frame_code = pppcnf_pkg::CODE_REJ;
      else if (pick < 78) it.frame_code = pppcnf_pkg::CODE_TREQ;
      else if (pick < 90) it.frame_code = pppcnf_pkg::CODE_TACK;
      else if (pick < 95) it.frame_code = pppcnf_pkg::CODE_CREJ;
      if ((it.frame_code == pppcnf_pkg::CODE_ACK || it.frame_code == pppcnf_pkg::CODE_NAK ||
           it.frame_code == pppcnf_pkg::CODE_REJ) && $urandom_range(0, 3) != 0)
         it.frame_ident = pend_id;
      if ($urandom_range(0, 99) < 88) begin
         it.declared_length = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 4091))
                                                            : 16'($urandom_range(0, 60));
         nb = int'(it.declared_length) + 4 + $urandom_range(0, 3);
         if (nb > 4095) nb = 4095;
         it.frame_bytes = 12'(nb);
      end
      return it;
   endfunction

   // present one beat after a random gap, hold until taken, then queue its replies
   task automatic push_item(input pppcnf_pkg::item_type it, input logic typed, input int n,
                            input reply_type r0, input reply_type r1);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.command;
      req_tdata  <= {2'b00, it.option_verdict, it.declared_length, it.frame_bytes,
                     it.frame_ident, it.frame_code, it.frame_protocol};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      negotiate_step(it);
      if (typed) begin
         if (n > 0) reply_q.push_back(r0);
         if (n > 1) reply_q.push_back(r1);
      end else begin
         foreach (step_buf[k])
            reply_q.push_back('{step_buf[k].out_kind, step_buf[k].out_code,
                                step_buf[k].out_ident, lnk_phase,
                                k == step_buf.size() - 1});
      end
   endtask

   task automatic write_regs(input logic [15:0] v_max, input logic [15:0] v_restart,
                             input logic [15:0] v_proto);
      logic [1:0]  idx;
      logic [15:0] val;
      for (int i = 0; i < 4; i++) begin
         case (i)
            0:       begin idx = pppcnf_pkg::CSR_MAX_REQUESTS;  val = v_max;     end
            1:       begin idx = pppcnf_pkg::CSR_RESTART_TICKS; val = v_restart; end
            2:       begin idx = pppcnf_pkg::CSR_OWN_PROTOCOL;  val = v_proto;   end
            default: begin idx = CSR_UNUSED;                    val = 16'hFFFF;  end
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= val;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            pppcnf_pkg::CSR_MAX_REQUESTS:  cfg_max_req = val[7:0];
            pppcnf_pkg::CSR_RESTART_TICKS: cfg_restart = val;
            pppcnf_pkg::CSR_OWN_PROTOCOL:  cfg_proto = val;
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // drop valid, drain every reply, then allow for beats still in flight that answer nothing
   task automatic settle();
      req_tvalid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      got = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8],
              pppcnf_pkg::phase_type'(rsp_tdata[18:16]), rsp_tlast};
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         if (reply_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result beat kind %0d code %0d ident %0d state %0d last %0d",
                     $time, got.kind, got.code, got.ident, got.state, got.is_last);
         end else begin
            want = reply_q.pop_front();
            if (got.kind !== want.kind || got.code !== want.code ||
                got.ident !== want.ident || got.state !== want.state ||
                got.is_last !== want.is_last) begin
               fail_count++;
               $display("%0t: mismatch, expected kind %0d code %0d ident %0d state %0d last %0d",
                        $time, want.kind, want.code, want.ident, want.state, want.is_last);
               $display("%0t:           actual   kind %0d code %0d ident %0d state %0d last %0d",
                        $time, got.kind, got.code, got.ident, got.state, got.is_last);
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_ppp_control_negotiation_fsm_core failed");
      $finish;
   end

   initial begin
      plan_row_type         plan[$];
      pppcnf_pkg::item_type tick0;
      logic [15:0]          v_max;
      logic [15:0]          v_restart;
      logic [15:0]          v_proto;
      logic [15:0]          own;

      own   = pppcnf_pkg::RST_OWN_PROTOCOL;
      tick0 = '{pppcnf_pkg::CMD_TICK, 16'h0, 8'h0, 8'h0, 12'h0, 16'h0, 2'h0};

      // after reset: drops, protocol reject, a stray answer, then one full negotiation
      plan.push_back('{tick0, 1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_REQ, 8'h00, 12'd3, 16'd0,
                                 pppcnf_pkg::VERDICT_ACK, 16'h0000),
                       1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_REQ, 8'hFF, 12'hFFF, 16'hFFFF,
                                 VERDICT_ODD, 16'hFFFF),
                       1'b1, 1,
                       '{pppcnf_pkg::KIND_PROTO_REJ, 8'd0, 8'd0, pppcnf_pkg::PH_STOPPED, 1'b1},
                       NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_REQ, 8'h00, 12'd6, 16'd0,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_REQ, 8'h00, 12'd8, 16'hFFFF,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(CODE_NONE, 8'h00, 12'd8, 16'd4, pppcnf_pkg::VERDICT_ACK, own),
                       1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(CODE_TOP, 8'h00, 12'd8, 16'd4, pppcnf_pkg::VERDICT_ACK, own),
                       1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_TACK, 8'h00, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_CREJ, 8'h00, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_ACK, 8'h00, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b1, 1,
                       '{pppcnf_pkg::KIND_PACKET, pppcnf_pkg::CODE_TACK, 8'd0,
                         pppcnf_pkg::PH_STOPPED, 1'b1},
                       NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_NAK, 8'h00, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b1, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_REQ, 8'h55, 12'hFFF, 16'd4091,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      repeat (3) plan.push_back('{tick0, 1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_ACK, 8'hFF, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_ACK, 8'h01, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_REQ, 8'h00, 12'd9, 16'd5, VERDICT_ODD, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_REQ, 8'hAA, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_NAK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_NAK, 8'h02, 12'd8, 16'd4, VERDICT_REJ, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_ACK, 8'h03, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_REQ, 8'h10, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_TREQ, 8'h80, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_TACK, 8'h00, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});
      plan.push_back('{frame_hdr(pppcnf_pkg::CODE_TREQ, 8'h00, 12'd8, 16'd4,
                                 pppcnf_pkg::VERDICT_ACK, own),
                       1'b0, 0, NO_REPLY, NO_REPLY});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) push_item(plan[i].it, plan[i].typed, plan[i].n, plan[i].r0, plan[i].r1);

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 85 : 0;
         recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 10 : 0;
         case (ph)
            0:       begin v_max = 16'd10;   v_restart = 16'd3;     v_proto = 16'hC021; end
            1:       begin v_max = 16'd1;    v_restart = 16'd1;     v_proto = 16'h8021; end
            2:       begin v_max = 16'hFFFF; v_restart = 16'hFFFF;  v_proto = 16'hFFFF; end
            3:       begin v_max = 16'd0;    v_restart = 16'd0;     v_proto = 16'h0000; end
            4:       begin v_max = 16'd3;    v_restart = 16'd2;     v_proto = 16'hC223; end
            default: begin v_max = 16'h0102; v_restart = 16'd5;     v_proto = 16'hC021; end
         endcase
         write_regs(v_max, v_restart, v_proto);
         repeat (RANDOM_ITEMS) push_item(random_item(), 1'b0, 0, NO_REPLY, NO_REPLY);
      end
      settle();

      $display("Covered %0d input beats (%0d from the directed table) and %0d result beats,",
               items_sent, plan.size(), replies_seen);
      $display("over six register settings with sender and receiver stalls both ways.");
      if (fail_count == 0) begin
         $display("tb_ppp_control_negotiation_fsm_core passed");
      end else begin
         $display("tb_ppp_control_negotiation_fsm_core failed");
      end
      $finish;
   end

endmodule
